>>> src/sdh_pkg.sv
// Shared types, register offsets and fixed values of the SD host register block.
// Depends on nothing; the top level and sdh_read_fmt import it.
package sdh_pkg;

   localparam int OFFSET_W = 14;
   localparam int WIDX_W   = OFFSET_W - 2;
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      OP_RD_BYTE = 2'd0,
      OP_RD_HALF = 2'd1,
      OP_RD_WORD = 2'd2,
      OP_WR_WORD = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROC
   } state_type;

   // Word indexes of the registers with special behavior.
   localparam logic [WIDX_W-1:0] XFERTYP_WIDX = WIDX_W'(14'h00C >> 2);
   localparam logic [WIDX_W-1:0] PRSSTAT_WIDX = WIDX_W'(14'h024 >> 2);
   localparam logic [WIDX_W-1:0] SYSCTL_WIDX  = WIDX_W'(14'h02C >> 2);
   localparam logic [WIDX_W-1:0] IRQSTAT_WIDX = WIDX_W'(14'h030 >> 2);
   localparam logic [WIDX_W-1:0] HOSTCAP_WIDX = WIDX_W'(14'h040 >> 2);
   localparam logic [WIDX_W-1:0] HOSTVER_WIDX = WIDX_W'(14'h0FC >> 2);

   localparam logic [DATA_W-1:0] SYSCTL_RESET   = 32'h0000_8008;
   localparam logic [DATA_W-1:0] SYSCTL_SELFCLR = 32'h0F00_0000;
   localparam logic [DATA_W-1:0] HOSTCAP_VALUE  = 32'h07F3_0000;
   localparam logic [DATA_W-1:0] HOSTVER_VALUE  = 32'h0000_1201;
   localparam logic [DATA_W-1:0] PRSSTAT_VALUE  = 32'hFF80_0008;
   localparam logic [DATA_W-1:0] RSPTYP_MASK    = 32'h0003_0000;
   localparam logic [DATA_W-1:0] IRQ_CC         = 32'h0000_0001;
   localparam logic [DATA_W-1:0] IRQ_CTOE       = 32'h0001_0000;

   function automatic logic is_fixed(input logic [WIDX_W-1:0] widx);
      return (widx == PRSSTAT_WIDX) || (widx == HOSTCAP_WIDX) || (widx == HOSTVER_WIDX);
   endfunction

   // A transfer-type write needs the interrupt status word, not its own entry.
   function automatic logic [WIDX_W-1:0] read_widx(input opcode_type op,
                                                  input logic [WIDX_W-1:0] widx);
      if (op == OP_WR_WORD && widx == XFERTYP_WIDX) begin
         return IRQSTAT_WIDX;
      end
      return widx;
   endfunction

endpackage

>>> src/sdh_if.sv
// Request and response channel interfaces with valid/ready handshake.
// Depends on nothing.
interface sdh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [13:0] byte_offset;
   logic [31:0] write_data;

   modport source (output valid, output opcode, output byte_offset, output write_data,
                   input ready);
   modport sink   (input valid, input opcode, input byte_offset, input write_data,
                   output ready);
endinterface

interface sdh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

>>> src/sd_host_register_block_no_card.sv
// Top level of the SD host register block (no card present): control FSM around one RAM.
// Depends on sdh_pkg, sdh_if, sdh_ram and sdh_read_fmt.
//
//   Channel   Direction  Handshake          Payload
//   req_bus   in         valid/ready        opcode, byte_offset, write_data
//   rsp_bus   out        valid/ready        read_data
//
// The accept cycle of a request issues the RAM read (and any plain write); ST_PROC then
// uses the registered RAM data and does the read-modify-write.
// After reset a clearing pass writes the reset value into every RAM entry; no request
// is accepted meanwhile. Reset is synchronous and active high.
// A response waiting on rsp_bus does not block the next accept; the block only holds
// in ST_PROC until the response register is free.
module sd_host_register_block_no_card #(
   parameter int WINDOW_WORDS = 4096
) (
   input  logic     clock,
   input  logic     reset,
   sdh_req_if.sink  req_bus,
   sdh_rsp_if.source rsp_bus
);
   import sdh_pkg::*;

   localparam int                AW           = $clog2(WINDOW_WORDS);
   localparam logic [AW-1:0]     LAST_ENTRY   = AW'(WINDOW_WORDS - 1);
   localparam logic [WIDX_W:0]   WINDOW_LIMIT = (WIDX_W + 1)'(WINDOW_WORDS);

   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_cnt_ff, clr_cnt_in;
   opcode_type              op_ff;
   logic [OFFSET_W-1:0]     offset_ff;
   logic [DATA_W-1:0]       wdata_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;

   opcode_type              req_op;
   logic [WIDX_W-1:0]       req_widx, held_widx, rd_widx;
   logic                    req_fire, req_in_range, held_in_range, out_free;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [DATA_W-1:0]       wr_data, mem_word, fmt_data;

   assign req_op        = opcode_type'(req_bus.opcode);
   assign req_widx      = req_bus.byte_offset[OFFSET_W-1:2];
   assign held_widx     = offset_ff[OFFSET_W-1:2];
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_in_range  = {1'b0, req_widx} < WINDOW_LIMIT;
   assign held_in_range = {1'b0, held_widx} < WINDOW_LIMIT;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // The read address is kept stable through ST_PROC, so a stall re-reads it.
   always_comb begin
      if (state_ff == ST_PROC) begin
         rd_widx = read_widx(op_ff, held_widx);
      end else begin
         rd_widx = read_widx(req_op, req_widx);
      end
   end
   assign rd_addr = rd_widx[AW-1:0];

   sdh_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WINDOW_WORDS)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (mem_word)
   );

   sdh_read_fmt u_read_fmt (
      .opcode    (op_ff),
      .byte_sel  (offset_ff[1:0]),
      .widx      (held_widx),
      .in_range  (held_in_range),
      .mem_word  (mem_word),
      .read_data (fmt_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == LAST_ENTRY) state_in = ST_IDLE;
         ST_IDLE:  if (req_fire) state_in = ST_PROC;
         ST_PROC:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == ST_IDLE);
      wr_en         = 1'b0;
      wr_addr       = req_widx[AW-1:0];
      wr_data       = req_bus.write_data;
      clr_cnt_in    = clr_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = (clr_cnt_ff == SYSCTL_WIDX[AW-1:0]) ? SYSCTL_RESET : '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            // Plain and system-control writes go straight in; interrupt status waits
            // for its old value.
            if (req_fire && req_op == OP_WR_WORD && req_in_range && !is_fixed(req_widx)
                && req_widx != IRQSTAT_WIDX) begin
               wr_en = 1'b1;
               if (req_widx == SYSCTL_WIDX) begin
                  wr_data = req_bus.write_data & ~SYSCTL_SELFCLR;
               end
            end
         end
         ST_PROC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fmt_data;
               if (op_ff == OP_WR_WORD) begin
                  wr_addr = IRQSTAT_WIDX[AW-1:0];
                  if (held_widx == XFERTYP_WIDX) begin
                     wr_en   = 1'b1;
                     wr_data = mem_word | IRQ_CC
                               | (((wdata_ff & RSPTYP_MASK) != '0) ? IRQ_CTOE : '0);
                  end else if (held_widx == IRQSTAT_WIDX) begin
                     wr_en   = 1'b1;
                     wr_data = mem_word & ~wdata_ff;
                  end
               end
            end
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         op_ff     <= req_op;
         offset_ff <= req_bus.byte_offset;
         wdata_ff  <= req_bus.write_data;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;

endmodule

>>> src/sdh_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module sdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

endmodule

>>> src/sdh_read_fmt.sv
// Read path: substitutes the fixed read-only words, returns zero out of range and selects the byte or halfword lane.
// Depends on sdh_pkg.
module sdh_read_fmt (
   input  logic [1:0]  opcode,
   input  logic [1:0]  byte_sel,
   input  logic [11:0] widx,
   input  logic        in_range,
   input  logic [31:0] mem_word,
   output logic [31:0] read_data
);
   import sdh_pkg::*;

   logic [DATA_W-1:0] word;
   opcode_type        op;

   assign op = opcode_type'(opcode);

   always_comb begin
      if (widx == PRSSTAT_WIDX) begin
         word = PRSSTAT_VALUE;
      end else if (widx == HOSTCAP_WIDX) begin
         word = HOSTCAP_VALUE;
      end else if (widx == HOSTVER_WIDX) begin
         word = HOSTVER_VALUE;
      end else if (in_range) begin
         word = mem_word;
      end else begin
         word = '0;
      end
   end

   always_comb begin
      case (op)
         OP_RD_BYTE: begin
            case (byte_sel)
               2'd0:    read_data = {24'd0, word[7:0]};
               2'd1:    read_data = {24'd0, word[15:8]};
               2'd2:    read_data = {24'd0, word[23:16]};
               default: read_data = {24'd0, word[31:24]};
            endcase
         end
         OP_RD_HALF: read_data = byte_sel[1] ? {16'd0, word[31:16]} : {16'd0, word[15:0]};
         OP_RD_WORD: read_data = word;
         default:    read_data = '0;
      endcase
   end

endmodule
